// File: src/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masks the check.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masks the check.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/qrm_pkg.sv
// Types and constants for the quaternion to rotation matrix pipeline.
// Depends on nothing; used by every module of the block.
package qrm_pkg;

  localparam int IN_W  = 16;          // quaternion component width
  localparam int FRAC  = 14;          // fraction bits of the matrix entries
  localparam int OUT_W = FRAC + 2;    // matrix entry width
  localparam int PW    = 2 * IN_W;    // product width
  localparam int DW    = 2 * IN_W + 1; // norm squared, remainder width
  localparam int NW    = 2 * IN_W + 2; // signed numerator width
  localparam int RW    = DW + 1;       // shifted remainder width
  localparam int NENT  = 9;            // matrix entries
  localparam int NSTEP = FRAC + 1;     // quotient bits after the first

  localparam logic [OUT_W-1:0] ONE_FX = OUT_W'(1) << FRAC;

  typedef struct packed {
    logic signed [IN_W-1:0] q_scalar;
    logic signed [IN_W-1:0] q_i;
    logic signed [IN_W-1:0] q_j;
    logic signed [IN_W-1:0] q_k;
  } quat_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] m00;
    logic signed [OUT_W-1:0] m01;
    logic signed [OUT_W-1:0] m02;
    logic signed [OUT_W-1:0] m10;
    logic signed [OUT_W-1:0] m11;
    logic signed [OUT_W-1:0] m12;
    logic signed [OUT_W-1:0] m20;
    logic signed [OUT_W-1:0] m21;
    logic signed [OUT_W-1:0] m22;
    logic                    zero_error;
  } mat_t;

  // Divider state carried between stages.
  typedef struct packed {
    logic [DW-1:0]                 den;
    logic [NENT-1:0]               neg;
    logic [NENT-1:0][DW-1:0]       rem;
    logic [NENT-1:0][OUT_W-1:0]    quo;
    logic                          zero;
  } div_t;

endpackage

// File: src/qrm_front.sv
// Front end: products, numerators and norm, then magnitudes and first quotient bit.
// Depends on qrm_pkg.
module qrm_front import qrm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  quat_t in_data,
  output logic  out_valid,
  output div_t  out_data
);

  // stage A: ten products
  logic va;
  logic signed [PW-1:0] aa, bb, cc, dd, bc, da, bd, ca, cd, ba;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      aa <= in_data.q_scalar * in_data.q_scalar;
      bb <= in_data.q_i * in_data.q_i;
      cc <= in_data.q_j * in_data.q_j;
      dd <= in_data.q_k * in_data.q_k;
      bc <= in_data.q_i * in_data.q_j;
      da <= in_data.q_k * in_data.q_scalar;
      bd <= in_data.q_i * in_data.q_k;
      ca <= in_data.q_j * in_data.q_scalar;
      cd <= in_data.q_j * in_data.q_k;
      ba <= in_data.q_i * in_data.q_scalar;
    end
  end

  // stage B: signed numerators and norm squared
  logic signed [NW-1:0] xaa, xbb, xcc, xdd, xbc, xda, xbd, xca, xcd, xba;
  assign xaa = NW'(aa);
  assign xbb = NW'(bb);
  assign xcc = NW'(cc);
  assign xdd = NW'(dd);
  assign xbc = NW'(bc);
  assign xda = NW'(da);
  assign xbd = NW'(bd);
  assign xca = NW'(ca);
  assign xcd = NW'(cd);
  assign xba = NW'(ba);

  logic vb;
  logic [DW-1:0] n2;
  logic signed [NENT-1:0][NW-1:0] num;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2     <= DW'(xaa + xbb + xcc + xdd);
      num[0] <= (xaa + xbb) - (xcc + xdd);
      num[1] <= (xbc - xda) <<< 1;
      num[2] <= (xbd + xca) <<< 1;
      num[3] <= (xbc + xda) <<< 1;
      num[4] <= (xaa + xcc) - (xbb + xdd);
      num[5] <= (xcd - xba) <<< 1;
      num[6] <= (xbd - xca) <<< 1;
      num[7] <= (xcd + xba) <<< 1;
      num[8] <= (xaa + xdd) - (xbb + xcc);
    end
  end

  // stage C: magnitudes; |num| <= n2 so the integer quotient bit is an equality
  logic [NENT-1:0][DW-1:0] mag;
  always_comb begin
    for (int e = 0; e < NENT; e++) begin
      mag[e] = num[e][NW-1] ? DW'(-num[e]) : DW'(num[e]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.den  <= n2;
      out_data.zero <= (n2 == '0);
      for (int e = 0; e < NENT; e++) begin
        out_data.neg[e] <= num[e][NW-1];
        out_data.rem[e] <= (mag[e] == n2) ? '0 : mag[e];
        out_data.quo[e] <= OUT_W'(mag[e] == n2);
      end
    end
  end

endmodule

// File: src/qrm_div_step.sv
// One restoring division step for all nine entries: one quotient bit each.
// Depends on qrm_pkg.
module qrm_div_step import qrm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  div_t in_data,
  output logic out_valid,
  output div_t out_data
);

  logic [NENT-1:0][RW-1:0] shl;
  logic [NENT-1:0]         ge;

  // shift, compare against the norm
  always_comb begin
    for (int e = 0; e < NENT; e++) begin
      shl[e] = {in_data.rem[e], 1'b0};
      ge[e]  = (shl[e] >= {1'b0, in_data.den});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.den  <= in_data.den;
      out_data.neg  <= in_data.neg;
      out_data.zero <= in_data.zero;
      for (int e = 0; e < NENT; e++) begin
        out_data.rem[e] <= ge[e] ? DW'(shl[e] - {1'b0, in_data.den}) : DW'(shl[e]);
        out_data.quo[e] <= {in_data.quo[e][OUT_W-2:0], ge[e]};
      end
    end
  end

endmodule

// File: src/qrm_round.sv
// Output stage: round half away from zero, clamp, apply sign, zero override.
// Depends on qrm_pkg.
module qrm_round import qrm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  div_t in_data,
  output logic out_valid,
  output mat_t out_data
);

  logic [NENT-1:0][OUT_W:0]   sum;
  logic [NENT-1:0][OUT_W-1:0] mg;
  logic [NENT-1:0][OUT_W-1:0] ent;

  always_comb begin
    for (int e = 0; e < NENT; e++) begin
      sum[e] = {1'b0, in_data.quo[e]} + (OUT_W + 1)'(1);
      mg[e]  = sum[e][OUT_W:1];
      if (mg[e] > ONE_FX) begin
        mg[e] = ONE_FX;
      end
      ent[e] = in_data.neg[e] ? OUT_W'(-mg[e]) : mg[e];
      if (in_data.zero) begin
        ent[e] = (e % 4 == 0) ? ONE_FX : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.m00        <= ent[0];
      out_data.m01        <= ent[1];
      out_data.m02        <= ent[2];
      out_data.m10        <= ent[3];
      out_data.m11        <= ent[4];
      out_data.m12        <= ent[5];
      out_data.m20        <= ent[6];
      out_data.m21        <= ent[7];
      out_data.m22        <= ent[8];
      out_data.zero_error <= in_data.zero;
    end
  end

endmodule

// File: src/quaternion_to_rotation_matrix_core.sv
// Quaternion to 3x3 rotation matrix, fully pipelined.
// Depends on qrm_pkg, qrm_front, qrm_div_step, qrm_round.
//
// Usage:
//   Input channel q_valid / q_stall / q_data carries one quaternion (scalar,
//   i, j, k) as signed integers; it need not be unit length. Output channel
//   m_valid / m_stall / m_data carries the nine Q1.FRAC entries of the
//   rotation matrix of the normalized quaternion plus zero_error.
//   Entries are ratio * 2^FRAC rounded half away from zero, clamped to
//   +-2^FRAC. A zero quaternion gives the identity with zero_error set.
// Timing:
//   The pipe holds three front stages (products, numerators, magnitudes),
//   one stage per remaining quotient bit of the restoring divider
//   (FRAC+1), and one rounding stage.
//   One quaternion is taken every cycle while the output is not stalled.
// Reset and stall:
//   rst clears all valid bits; data registers are not reset.
//   When the output holds a result and m_stall is high, the whole pipe
//   freezes and q_stall rises, so nothing is lost or repeated.
module quaternion_to_rotation_matrix_core import qrm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  q_valid,
  output logic  q_stall,
  input  quat_t q_data,
  output logic  m_valid,
  input  logic  m_stall,
  output mat_t  m_data
);

  logic en;
  assign en      = !(m_valid && m_stall);
  assign q_stall = !en;

  logic [NSTEP:0] sv;
  div_t           sd [NSTEP+1];

  qrm_front u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(q_valid), .in_data(q_data),
    .out_valid(sv[0]), .out_data(sd[0])
  );

  // divider chain, one quotient bit per stage
  for (genvar s = 0; s < NSTEP; s++) begin : g_step
    qrm_div_step u_step (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(sv[s]), .in_data(sd[s]),
      .out_valid(sv[s+1]), .out_data(sd[s+1])
    );
  end

  qrm_round u_round (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(sv[NSTEP]), .in_data(sd[NSTEP]),
    .out_valid(m_valid), .out_data(m_data)
  );

endmodule

// File: src/qrm_checker.sv
// Port-level checks for the quaternion to rotation matrix block, with bind.
// Depends on qrm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qrm_checker import qrm_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  q_valid,
  input logic  q_stall,
  input quat_t q_data,
  input logic  m_valid,
  input logic  m_stall,
  input mat_t  m_data
);

  // identity matrix on the result port
  logic id_ok;
  assign id_ok = m_data.m00 == ONE_FX && m_data.m11 == ONE_FX && m_data.m22 == ONE_FX &&
                 m_data.m01 == '0 && m_data.m02 == '0 && m_data.m10 == '0 &&
                 m_data.m12 == '0 && m_data.m20 == '0 && m_data.m21 == '0;

  // top-left entry within the clamp
  logic diag_ok;
  assign diag_ok = $signed(m_data.m00) <= $signed(ONE_FX) &&
                   $signed(m_data.m00) >= -$signed(ONE_FX);

  // a stalled result transfer holds its payload
  `ASSERT_NEXT(a_out_hold, clk, rst, m_valid && m_stall, m_valid && $stable(m_data), "stalled result changed")

  // a stalled input transfer holds its payload
  `ASSERT_NEXT(a_in_hold, clk, rst, q_valid && q_stall, q_valid && $stable(q_data), "stalled input changed")

  // input backpressure only comes from a stalled, occupied output
  `ASSERT_IMPL(a_in_stall, clk, rst, q_stall, m_valid && m_stall, "input stalled without cause")

  // zero quaternion returns the identity
  `ASSERT_IMPL(a_zero_id, clk, rst, m_valid && m_data.zero_error, id_ok, "zero input not identity")

  // top-left entry stays within the clamp
  `ASSERT_IMPL(a_diag_rng, clk, rst, m_valid, diag_ok, "entry out of range")

endmodule

bind quaternion_to_rotation_matrix_core qrm_checker u_qrm_checker (
  .clk(clk), .rst(rst),
  .q_valid(q_valid), .q_stall(q_stall), .q_data(q_data),
  .m_valid(m_valid), .m_stall(m_stall), .m_data(m_data)
);

// File: tb/tb_quaternion_to_rotation_matrix_core.sv
// Testbench for quaternion_to_rotation_matrix_core: drives quaternions, predicts
// each rotation matrix with exact integer arithmetic and checks every result transfer.
// Depends on qrm_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_quaternion_to_rotation_matrix_core;
  import qrm_pkg::*;

  localparam int LATENCY   = FRAC + 5;
  localparam int WD_LIMIT  = 20000;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  q_valid = 1'b0;
  logic  q_stall;
  quat_t q_data = '0;
  logic  m_valid;
  logic  m_stall = 1'b0;
  mat_t  m_data;

  mat_t pending_mats[$];
  int   mismatch_cnt = 0;
  int   idle_cycles = 0;
  bit   send_gaps = 1'b1;
  bit   recv_gaps = 1'b1;
  int   long_hold = 0;

  quaternion_to_rotation_matrix_core u_top (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_stall(q_stall), .q_data(q_data),
    .m_valid(m_valid), .m_stall(m_stall), .m_data(m_data)
  );

  always #10 clk = ~clk;

  // One matrix entry: round(num * 2^FRAC / den) half away from zero, clamped.
  function automatic logic [OUT_W-1:0] entry_fx(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = ((mag << (FRAC + 1)) / den + 1) >>> 1;
    if (q > (64'sd1 <<< FRAC)) q = 64'sd1 <<< FRAC;
    return (num < 0) ? OUT_W'(-q) : OUT_W'(q);
  endfunction

  function automatic mat_t rotation_of(quat_t q);
    longint a, b, c, d, aa, bb, cc, dd, n2;
    mat_t m;
    a = q.q_scalar; b = q.q_i; c = q.q_j; d = q.q_k;
    aa = a * a; bb = b * b; cc = c * c; dd = d * d;
    n2 = aa + bb + cc + dd;
    m = '0;
    if (n2 == 0) begin
      m.m00 = ONE_FX; m.m11 = ONE_FX; m.m22 = ONE_FX;
      m.zero_error = 1'b1;
      return m;
    end
    m.m00 = entry_fx(aa + bb - cc - dd, n2);
    m.m01 = entry_fx(2 * (b * c - d * a), n2);
    m.m02 = entry_fx(2 * (b * d + c * a), n2);
    m.m10 = entry_fx(2 * (b * c + d * a), n2);
    m.m11 = entry_fx(aa - bb + cc - dd, n2);
    m.m12 = entry_fx(2 * (c * d - b * a), n2);
    m.m20 = entry_fx(2 * (b * d - c * a), n2);
    m.m21 = entry_fx(2 * (c * d + b * a), n2);
    m.m22 = entry_fx(aa - bb - cc + dd, n2);
    return m;
  endfunction

  // Send one quaternion, with an optional idle burst before it.
  // Valid drops only for an idle burst, so back-to-back sends keep it high.
  task automatic send_quat(input quat_t q);
    int gap;
    gap = (send_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
    if (gap > 0) begin
      q_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    q_valid <= 1'b1;
    q_data  <= q;
    pending_mats.push_back(rotation_of(q));
    do @(posedge clk); while (q_stall);
  endtask

  function automatic logic [IN_W-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return IN_W'($urandom_range(0, 7)) - 16'sd3;
      default: return IN_W'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_quat('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
    send_quat('{16'sd1, 16'sd0, 16'sd0, 16'sd0});
    send_quat('{16'sd0, 16'sd1, 16'sd0, 16'sd0});
    send_quat('{16'sd0, 16'sd0, -16'sd1, 16'sd0});
    send_quat('{16'sd0, 16'sd0, 16'sd0, 16'sd1});
    send_quat('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    send_quat('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    send_quat('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
    send_quat('{16'sh8000, 16'sd0, 16'sd0, 16'sd0});
    send_quat('{16'sd1, 16'sd1, 16'sd1, 16'sd1});
    send_quat('{16'sd3, 16'sd1, -16'sd1, 16'sd0});
    send_quat('{16'sd1, 16'sd2, 16'sd3, 16'sd4});
    send_quat('{-16'sd1, 16'sd0, 16'sd0, 16'sd0});
    send_quat('{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa});
    send_quat('{16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555});
  endtask

  task automatic test_random(input int n);
    repeat (n) send_quat('{rand_comp(), rand_comp(), rand_comp(), rand_comp()});
  endtask

  // Receiver holds off long enough for the pipe to fill and stall its input.
  task automatic test_backpressure();
    long_hold = 60;
    send_gaps = 1'b0;
    test_random(80);
    send_gaps = 1'b1;
  endtask

  task automatic test_full_rate();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    test_random(200);
  endtask

  // Output stall generator: random bursts, plus the long hold on request.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (long_hold > 0) begin
        m_stall <= 1'b1;
        repeat (long_hold) @(posedge clk);
        long_hold = 0;
      end
      if (recv_gaps && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 14);
        m_stall <= 1'b1;
        repeat (n - 1) @(posedge clk);
      end else begin
        m_stall <= 1'b0;
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    mat_t exp_mat;
    if (!rst && m_valid && !m_stall) begin
      if (pending_mats.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("ERROR: unexpected result %h", m_data);
      end else begin
        exp_mat = pending_mats.pop_front();
        if (m_data !== exp_mat) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("ERROR: matrix mismatch expected %h actual %h", exp_mat, m_data);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (q_valid && !q_stall) || (m_valid && !m_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int wait_cnt;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(500);
    test_backpressure();
    test_random(450);
    test_full_rate();
    q_valid <= 1'b0;
    wait_cnt = 0;
    while (pending_mats.size() != 0 && wait_cnt < 100 * WD_LIMIT) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (LATENCY + 5) @(posedge clk);
    if (mismatch_cnt == 0 && pending_mats.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
